FILE: rtl/lcpd_pkg.sv
package lcpd_pkg;

	localparam int CHANNELS_DEF     = 5;
	localparam int SEARCH_STEPS_DEF = 15;

	// Q1.15 value for 1.0; levels above it saturate.
	localparam logic [15:0] LEVEL_ONE = 16'd32768;
	localparam logic [12:0] DUTY_MAX  = 13'd4096;
	localparam int          QUO_BITS  = 13;

	typedef enum logic [2:0] {
		OP_SET_LEVEL    = 3'd0,
		OP_SET_BRIGHT   = 3'd1,
		OP_SET_POWER    = 3'd2,
		OP_TOGGLE_POWER = 3'd3,
		OP_SET_TARGET   = 3'd4
	} op_t;

	localparam logic [1:0] CFG_SQUARE = 2'd0;
	localparam logic [1:0] CFG_LINEAR = 2'd1;
	localparam logic [1:0] CFG_RANGE  = 2'd2;

	typedef struct packed {
		logic        start;
		logic        ovf;
		logic [31:0] num;
		logic [15:0] den;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [12:0] quo;
	} div_rsp_t;

endpackage

FILE: rtl/lcpd_in_if.sv
interface lcpd_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  operation;
	logic [2:0]  channel;
	logic [15:0] value;

	modport source (output valid, output operation, output channel, output value, input ready);
	modport sink (input valid, input operation, input channel, input value, output ready);
endinterface

FILE: rtl/lcpd_out_if.sv
interface lcpd_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  channel_out;
	logic [12:0] duty;
	logic        last;

	modport source (output valid, output channel_out, output duty, output last, input ready);
	modport sink (input valid, input channel_out, input duty, input last, output ready);
endinterface

FILE: rtl/led_color_pwm_dimmer_core.sv
// A run starts in the cycle after the item, evaluates the brightness curve, then per
// lit channel evaluates its curve, takes the product on the shared 33x33 multiplier and
// runs the 13-step duty divider (cut short when the duty saturates); a dark channel
// skips both. A target-duty item runs its bisection steps before the run. Throughput: one
// item at a time; the next is taken the cycle after the last beat leaves. Reset: levels,
// brightness, power zero; S 64.0, L 0, 4096.
module led_color_pwm_dimmer_core #(
	parameter int CHANNELS     = lcpd_pkg::CHANNELS_DEF,
	parameter int SEARCH_STEPS = lcpd_pkg::SEARCH_STEPS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [19:0] cfg_wdata,
	lcpd_in_if.sink     in_bus,
	lcpd_out_if.source  out_bus
);
	import lcpd_pkg::*;

	localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int STEP_W = $clog2(SEARCH_STEPS + 1);
	localparam logic [3:0]        CH_LIMIT  = 4'(CHANNELS);
	localparam logic [CH_W-1:0]   CH_LAST   = CH_W'(CHANNELS - 1);
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(SEARCH_STEPS - 1);

	typedef enum logic [12:0] {
		S_IDLE     = 13'b0000000000001,
		S_START    = 13'b0000000000010,
		S_SX       = 13'b0000000000100,
		S_SQ       = 13'b0000000001000,
		S_LIN      = 13'b0000000010000,
		S_SUM      = 13'b0000000100000,
		S_BIS_MID  = 13'b0000001000000,
		S_BIS_CMP  = 13'b0000010000000,
		S_EMIT_CH  = 13'b0000100000000,
		S_PROD     = 13'b0001000000000,
		S_DIV_GO   = 13'b0010000000000,
		S_OUT      = 13'b0100000000000,
		S_DIV_WAIT = 13'b1000000000000
	} state_t;

	typedef enum logic [1:0] {
		MODE_SEARCH = 2'd0,
		MODE_BRIGHT = 2'd1,
		MODE_CHAN   = 2'd2
	} mode_t;

	state_t state_q;
	mode_t  mode_q;

	logic [15:0] sq_coef_q;
	logic [19:0] lin_coef_q;
	logic [15:0] rng_q;

	logic [15:0] lvl_q [CHANNELS];
	logic [15:0] bright_q;
	logic        power_q;

	logic [15:0]       x_q;
	logic [65:0]       mul_q;
	logic [31:0]       sqt_q;
	logic [32:0]       f_q;
	logic [32:0]       fb_q;
	logic [15:0]       lo_q;
	logic [15:0]       hi_q;
	logic [15:0]       tgt_q;
	logic [STEP_W-1:0] step_q;
	logic [CH_W-1:0]   wch_q;
	logic [CH_W-1:0]   ch_q;
	logic [12:0]       duty_q;

	logic [15:0]     value_clamp;
	logic            ch_ok;
	logic [CH_W-1:0] in_ch;
	logic            pwr_req;
	logic [16:0]     mid_sum;
	logic [32:0]     curve_sum;
	logic [16:0]     lum;
	logic [15:0]     lvl_cur;
	logic [32:0]     mul_a;
	logic [32:0]     mul_b;
	logic            mul_en;

	div_req_t div_req;
	div_rsp_t div_rsp;

	always_comb begin
		value_clamp = (in_bus.value > LEVEL_ONE) ? LEVEL_ONE : in_bus.value;
		ch_ok       = {1'b0, in_bus.channel} < CH_LIMIT;
		in_ch       = in_bus.channel[CH_W-1:0];
		pwr_req     = |in_bus.value;
		mid_sum     = {1'b0, lo_q} + {1'b0, hi_q};
		// Each curve term is floored on its own before the add.
		curve_sum   = {1'b0, sqt_q} + {5'd0, mul_q[34:7]};
		lum         = f_q[32:16];
		lvl_cur     = lvl_q[ch_q];
	end

	// Shared multiplier: S*x, (S*x)^2, L*x, then the two curve values.
	always_comb begin
		mul_a  = '0;
		mul_b  = '0;
		mul_en = 1'b1;
		unique case (state_q)
			S_SX: begin
				mul_a = {17'd0, sq_coef_q};
				mul_b = {17'd0, x_q};
			end
			S_SQ: begin
				mul_a = {1'b0, mul_q[31:0]};
				mul_b = {1'b0, mul_q[31:0]};
			end
			S_LIN: begin
				mul_a = {13'd0, lin_coef_q};
				mul_b = {17'd0, x_q};
			end
			S_PROD: begin
				mul_a = f_q;
				mul_b = fb_q;
			end
			default: begin
				mul_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mul_en) begin
			mul_q <= mul_a * mul_b;
		end
	end

	// The divider is started for one cycle only; the result is awaited afterwards.
	always_comb begin
		div_req.start = (state_q == S_DIV_GO);
		div_req.ovf   = |mul_q[65:64];
		div_req.num   = mul_q[63:32];
		div_req.den   = rng_q;
	end

	lcpd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			mode_q     <= MODE_BRIGHT;
			sq_coef_q  <= 16'd16384;
			lin_coef_q <= 20'd0;
			rng_q      <= 16'd4096;
			for (int i = 0; i < CHANNELS; i++) begin
				lvl_q[i] <= 16'd0;
			end
			bright_q   <= 16'd0;
			power_q    <= 1'b0;
			x_q        <= '0;
			sqt_q      <= '0;
			f_q        <= '0;
			fb_q       <= '0;
			lo_q       <= '0;
			hi_q       <= '0;
			tgt_q      <= '0;
			step_q     <= '0;
			wch_q      <= '0;
			ch_q       <= '0;
			duty_q     <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					CFG_SQUARE: sq_coef_q <= cfg_wdata[15:0];
					CFG_LINEAR: lin_coef_q <= cfg_wdata;
					CFG_RANGE:  rng_q <= cfg_wdata[15:0];
					default: ;
				endcase
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_bus.valid) begin
						unique case (in_bus.operation)
							OP_SET_LEVEL: begin
								if (ch_ok) begin
									lvl_q[in_ch] <= value_clamp;
									state_q      <= S_START;
								end
							end
							OP_SET_BRIGHT: begin
								bright_q <= value_clamp;
								state_q  <= S_START;
							end
							OP_SET_POWER: begin
								if (pwr_req != power_q) begin
									power_q <= pwr_req;
									state_q <= S_START;
								end
							end
							OP_TOGGLE_POWER: begin
								power_q <= !power_q;
								state_q <= S_START;
							end
							OP_SET_TARGET: begin
								if (ch_ok) begin
									wch_q   <= in_ch;
									tgt_q   <= in_bus.value;
									lo_q    <= 16'd0;
									hi_q    <= LEVEL_ONE;
									step_q  <= '0;
									mode_q  <= MODE_SEARCH;
									state_q <= S_BIS_MID;
								end
							end
							default: ;
						endcase
					end
				end
				S_START: begin
					x_q     <= bright_q;
					mode_q  <= MODE_BRIGHT;
					ch_q    <= '0;
					state_q <= S_SX;
				end
				S_SX: begin
					state_q <= S_SQ;
				end
				S_SQ: begin
					state_q <= S_LIN;
				end
				S_LIN: begin
					sqt_q   <= mul_q[61:30];
					state_q <= S_SUM;
				end
				S_SUM: begin
					unique case (mode_q)
						MODE_SEARCH: begin
							f_q     <= curve_sum;
							state_q <= S_BIS_CMP;
						end
						MODE_BRIGHT: begin
							fb_q    <= curve_sum;
							state_q <= S_EMIT_CH;
						end
						MODE_CHAN: begin
							f_q     <= curve_sum;
							state_q <= S_PROD;
						end
						default: begin
							state_q <= S_IDLE;
						end
					endcase
				end
				S_BIS_MID: begin
					x_q     <= mid_sum[16:1];
					state_q <= S_SX;
				end
				S_BIS_CMP: begin
					step_q <= step_q + 1'b1;
					// The level keeps the last midpoint tried, whether the search
					// hit the target exactly or ran out of steps.
					if (lum == {1'b0, tgt_q} || step_q == STEP_LAST) begin
						lvl_q[wch_q] <= x_q;
						state_q      <= S_START;
					end else begin
						if (lum < {1'b0, tgt_q}) begin
							lo_q <= x_q;
						end else begin
							hi_q <= x_q;
						end
						state_q <= S_BIS_MID;
					end
				end
				S_EMIT_CH: begin
					if (!power_q || lvl_cur == 16'd0) begin
						duty_q  <= 13'd0;
						state_q <= S_OUT;
					end else begin
						x_q     <= lvl_cur;
						mode_q  <= MODE_CHAN;
						state_q <= S_SX;
					end
				end
				S_PROD: begin
					state_q <= S_DIV_GO;
				end
				S_DIV_GO: begin
					state_q <= S_DIV_WAIT;
				end
				S_DIV_WAIT: begin
					if (div_rsp.done) begin
						duty_q  <= div_rsp.quo;
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_bus.ready) begin
						if (ch_q == CH_LAST) begin
							state_q <= S_IDLE;
						end else begin
							ch_q    <= ch_q + 1'b1;
							state_q <= S_EMIT_CH;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_bus.ready        = (state_q == S_IDLE);
	assign out_bus.valid       = (state_q == S_OUT);
	assign out_bus.channel_out = 3'(ch_q);
	assign out_bus.duty        = duty_q;
	assign out_bus.last        = (ch_q == CH_LAST);

	a_duty_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_bus.valid |-> out_bus.duty <= DUTY_MAX)
		else $error("duty above ceiling");

	a_dark_when_off: assert property (@(posedge clk) disable iff (!arst_n)
		out_bus.valid && !power_q |-> out_bus.duty == 13'd0)
		else $error("nonzero duty while power is off");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_bus.ready && out_bus.valid))
		else $error("input taken while a run is being reported");

	a_run_ends_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_bus.valid && out_bus.ready && out_bus.last |=> in_bus.ready)
		else $error("block not idle after last beat");

endmodule

FILE: rtl/lcpd_div.sv
module lcpd_div (
	input  logic               clk,
	input  logic               arst_n,
	input  lcpd_pkg::div_req_t req,
	output lcpd_pkg::div_rsp_t rsp
);
	import lcpd_pkg::*;

	localparam int CNT_W = $clog2(QUO_BITS);
	localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(QUO_BITS - 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [28:0]      rem_q;
	logic [27:0]      dv_q;
	logic [12:0]      quo_q;

	logic [15:0] den_eff;
	logic [28:0] lim;
	logic        sat;
	logic        ge;

	// A quotient above the duty ceiling is caught up front, so the
	// restoring loop only ever needs thirteen quotient bits.
	always_comb begin
		den_eff = (req.den == 16'd0) ? 16'd1 : req.den;
		lim     = {1'b0, den_eff, 12'd0} + {13'd0, den_eff};
		sat     = req.ovf || (req.num >= {3'd0, lim});
		ge      = rem_q >= {1'b0, dv_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			dv_q   <= '0;
			quo_q  <= '0;
		end else begin
			if (req.start) begin
				if (sat) begin
					quo_q  <= DUTY_MAX;
					done_q <= 1'b1;
				end else begin
					rem_q  <= req.num[28:0];
					dv_q   <= {den_eff, 12'd0};
					quo_q  <= '0;
					cnt_q  <= CNT_TOP;
					busy_q <= 1'b1;
					done_q <= 1'b0;
				end
			end else if (busy_q) begin
				if (ge) begin
					rem_q <= rem_q - {1'b0, dv_q};
				end
				quo_q  <= {quo_q[11:0], ge};
				dv_q   <= dv_q >> 1;
				cnt_q  <= cnt_q - 1'b1;
				done_q <= (cnt_q == '0);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
			end else begin
				done_q <= 1'b0;
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q)
		else $error("divider started while busy");

	a_quo_range: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> quo_q <= DUTY_MAX)
		else $error("divider quotient above duty ceiling");

	a_done_ends_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && cnt_q == '0 && !req.start |=> done_q && !busy_q)
		else $error("divider did not finish on last step");

endmodule

FILE: test/led_color_pwm_dimmer_core_test.sv
`timescale 1ns / 1ps

module led_color_pwm_dimmer_core_test;
	import lcpd_pkg::*;

	localparam int CHANNELS      = CHANNELS_DEF;
	localparam int SEARCH_STEPS  = SEARCH_STEPS_DEF;
	localparam int CODE_MAX      = 7;
	localparam int SETTLE_CYCLES = 300;
	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int PHASE_ITEMS   = 40;

	localparam logic [2:0] OP_FIRST_UNUSED = 3'd5;

	localparam logic [15:0] SQUARE_RESET = 16'd16384;
	localparam logic [19:0] LINEAR_RESET = 20'd0;
	localparam logic [15:0] RANGE_RESET  = 16'd4096;

	localparam int IDLE_NONE = 0;
	localparam int IDLE_HALF = 50;
	localparam int IDLE_BOTH = 38;

	typedef struct {
		logic [2:0]  operation;
		logic [2:0]  channel;
		logic [15:0] value;
	} dimmer_cmd_t;

	typedef struct {
		logic [2:0]  channel;
		logic [12:0] duty;
		logic        last;
	} duty_report_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_idx;
	logic [19:0] cfg_wdata;

	lcpd_in_if  cmd_bus ();
	lcpd_out_if duty_bus ();

	led_color_pwm_dimmer_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.in_bus    (cmd_bus),
		.out_bus   (duty_bus)
	);

	always #5 clk = ~clk;

	// Shadow of the dimmer state and its coefficient registers.
	logic [15:0] coef_square;
	logic [19:0] coef_linear;
	logic [15:0] pwm_div;
	logic [15:0] lamp_level [CHANNELS];
	logic [15:0] master_bright;
	logic        lamps_on;

	dimmer_cmd_t  pending_cmds [$];
	duty_report_t duty_queue [$];
	dimmer_cmd_t  next_cmd;
	duty_report_t want;

	int send_idle_pct;
	int stall_pct;
	int mismatch_count;
	int cycle_count;

	function automatic logic [15:0] clamp_level(logic [15:0] v);
		return (v > LEVEL_ONE) ? LEVEL_ONE : v;
	endfunction

	// Gamma curve with 16 fraction bits; both terms are floored before the sum.
	function automatic logic [63:0] curve_q16(logic [15:0] x);
		logic [63:0] sx;
		logic [63:0] lin;
		sx  = 64'(coef_square) * 64'(x);
		lin = (64'(coef_linear) * 64'(x)) >> 7;
		return ((sx * sx) >> 30) + lin;
	endfunction

	function automatic logic [12:0] duty_for(int ch);
		logic [127:0] prod;
		logic [127:0] quo;
		logic [63:0]  den;
		if (!lamps_on || lamp_level[ch] == 16'd0)
			return 13'd0;
		prod = 128'(curve_q16(lamp_level[ch])) * 128'(curve_q16(master_bright));
		// A product past 64 bits saturates.
		if (prod[127:64] != 64'd0)
			return DUTY_MAX;
		den = 64'((pwm_div == 16'd0) ? 16'd1 : pwm_div) << 32;
		quo = prod / 128'(den);
		return (quo > 128'(DUTY_MAX)) ? DUTY_MAX : quo[12:0];
	endfunction

	function automatic logic [15:0] level_for_duty(logic [15:0] target);
		logic [15:0] lo;
		logic [15:0] hi;
		logic [15:0] mid;
		logic [63:0] lum;
		lo  = 16'd0;
		hi  = LEVEL_ONE;
		mid = 16'd0;
		for (int i = 0; i < SEARCH_STEPS; i++) begin
			mid = 16'((17'(lo) + 17'(hi)) >> 1);
			lum = curve_q16(mid) >> 16;
			if (lum < 64'(target))
				lo = mid;
			else if (lum > 64'(target))
				hi = mid;
			else
				break;
		end
		return mid;
	endfunction

	function automatic void apply_command(logic [2:0] op, logic [2:0] ch, logic [15:0] val);
		logic changed;
		changed = 1'b0;
		case (op)
			OP_SET_LEVEL: begin
				if (ch < CHANNELS) begin
					lamp_level[ch] = clamp_level(val);
					changed = 1'b1;
				end
			end
			OP_SET_BRIGHT: begin
				master_bright = clamp_level(val);
				changed = 1'b1;
			end
			OP_SET_POWER: begin
				if ((val != 16'd0) != lamps_on) begin
					lamps_on = (val != 16'd0);
					changed = 1'b1;
				end
			end
			OP_TOGGLE_POWER: begin
				lamps_on = !lamps_on;
				changed = 1'b1;
			end
			OP_SET_TARGET: begin
				if (ch < CHANNELS) begin
					lamp_level[ch] = level_for_duty(val);
					changed = 1'b1;
				end
			end
			default: ;
		endcase
		if (changed) begin
			for (int c = 0; c < CHANNELS; c++)
				duty_queue.push_back('{3'(c), duty_for(c), c == CHANNELS - 1});
		end
	endfunction

	function automatic logic [15:0] random_level();
		case ($urandom_range(7))
			0: return 16'd0;
			1: return LEVEL_ONE;
			2: return 16'($urandom);
			3: return 16'($urandom_range(int'(LEVEL_ONE) + 1, 65535));
			default: return 16'($urandom_range(1, int'(LEVEL_ONE)));
		endcase
	endfunction

	task automatic report_mismatch(string msg);
		$display("mismatch at %0t: %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic queue_cmd(logic [2:0] op, logic [2:0] ch, logic [15:0] val);
		pending_cmds.push_back('{op, ch, val});
	endtask

	// Returns once every command is taken, every duty beat is in and the core has settled.
	task automatic wait_idle();
		do
			@(negedge clk);
		while (pending_cmds.size() != 0 || cmd_bus.valid || duty_queue.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic run_phase(logic [15:0] sq, logic [19:0] lin, logic [15:0] range,
			int idle, int stall);
		dimmer_cmd_t cmd;
		int pick;
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_idx   <= CFG_SQUARE;
		cfg_wdata <= 20'(sq);
		@(posedge clk);
		cfg_idx   <= CFG_LINEAR;
		cfg_wdata <= lin;
		@(posedge clk);
		cfg_idx   <= CFG_RANGE;
		cfg_wdata <= 20'(range);
		@(posedge clk);
		cfg_we    <= 1'b0;
		coef_square   = sq;
		coef_linear   = lin;
		pwm_div       = range;
		send_idle_pct = idle;
		stall_pct     = stall;
		for (int n = 0; n < PHASE_ITEMS; n++) begin
			pick          = $urandom_range(99);
			cmd.channel   = 3'($urandom_range(CHANNELS - 1));
			cmd.value     = random_level();
			if (pick < 34) begin
				cmd.operation = OP_SET_LEVEL;
			end else if (pick < 48) begin
				cmd.operation = OP_SET_BRIGHT;
			end else if (pick < 58) begin
				cmd.operation = OP_SET_POWER;
				cmd.value = ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom);
			end else if (pick < 64) begin
				cmd.operation = OP_TOGGLE_POWER;
			end else if (pick < 92) begin
				cmd.operation = OP_SET_TARGET;
				case ($urandom_range(3))
					0: cmd.value = 16'($urandom_range(int'(DUTY_MAX)));
					1: cmd.value = 16'($urandom);
					2: cmd.value = 16'($urandom_range(63));
					// A target taken from the curve at a random level can stop the search early.
					default: cmd.value = 16'(curve_q16(clamp_level(random_level())) >> 16);
				endcase
			end else if (pick < 96) begin
				cmd.operation = ($urandom_range(1) == 0) ? OP_SET_LEVEL : OP_SET_TARGET;
				cmd.channel   = 3'($urandom_range(CHANNELS, CODE_MAX));
			end else begin
				cmd.operation = 3'($urandom_range(int'(OP_FIRST_UNUSED), CODE_MAX));
			end
			pending_cmds.push_back(cmd);
		end
		wait_idle();
	endtask

	// Command driver: the prediction is made on the beat the core takes.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_bus.valid <= 1'b0;
		end else begin
			if (cmd_bus.valid && cmd_bus.ready)
				apply_command(cmd_bus.operation, cmd_bus.channel, cmd_bus.value);
			if (!cmd_bus.valid || cmd_bus.ready) begin
				if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_cmd = pending_cmds.pop_front();
					cmd_bus.valid     <= 1'b1;
					cmd_bus.operation <= next_cmd.operation;
					cmd_bus.channel   <= next_cmd.channel;
					cmd_bus.value     <= next_cmd.value;
				end else begin
					cmd_bus.valid <= 1'b0;
				end
			end
		end
	end

	// Duty monitor.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_bus.ready <= 1'b0;
		end else begin
			duty_bus.ready <= ($urandom_range(99) >= stall_pct);
			if (duty_bus.valid && duty_bus.ready) begin
				if (duty_queue.size() == 0) begin
					report_mismatch($sformatf("unexpected beat for channel %0d duty %0d",
						duty_bus.channel_out, duty_bus.duty));
				end else begin
					want = duty_queue.pop_front();
					if (duty_bus.channel_out !== want.channel)
						report_mismatch($sformatf("channel_out %0d, wanted %0d",
							duty_bus.channel_out, want.channel));
					if (duty_bus.duty !== want.duty)
						report_mismatch($sformatf("channel %0d duty %0d, wanted %0d",
							want.channel, duty_bus.duty, want.duty));
					if (duty_bus.last !== want.last)
						report_mismatch($sformatf("channel %0d last %0b, wanted %0b",
							want.channel, duty_bus.last, want.last));
				end
			end
		end
	end

	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("timeout after %0d cycles", cycle_count);
		$display("FAIL");
		$finish;
	end

	initial begin
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_idx           = CFG_SQUARE;
		cfg_wdata         = 20'd0;
		cmd_bus.valid     = 1'b0;
		cmd_bus.operation = OP_SET_LEVEL;
		cmd_bus.channel   = 3'd0;
		cmd_bus.value     = 16'd0;
		duty_bus.ready    = 1'b0;
		mismatch_count    = 0;
		cycle_count       = 0;
		send_idle_pct     = IDLE_NONE;
		stall_pct         = IDLE_NONE;
		coef_square       = SQUARE_RESET;
		coef_linear       = LINEAR_RESET;
		pwm_div           = RANGE_RESET;
		master_bright     = 16'd0;
		lamps_on          = 1'b0;
		for (int c = 0; c < CHANNELS; c++)
			lamp_level[c] = 16'd0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed commands against the reset coefficients.
		queue_cmd(OP_SET_LEVEL, 3'd0, LEVEL_ONE);
		queue_cmd(OP_SET_POWER, 3'd0, 16'd0);
		queue_cmd(OP_SET_POWER, 3'd0, 16'd1);
		queue_cmd(OP_SET_POWER, 3'd0, 16'h8000);
		queue_cmd(OP_SET_BRIGHT, 3'd0, 16'hFFFF);
		queue_cmd(OP_SET_LEVEL, 3'd1, 16'hFFFF);
		queue_cmd(OP_SET_LEVEL, 3'd2, 16'd1);
		queue_cmd(OP_SET_LEVEL, 3'd3, 16'd0);
		queue_cmd(OP_SET_LEVEL, 3'(CHANNELS - 1), LEVEL_ONE - 16'd1);
		queue_cmd(OP_SET_LEVEL, 3'(CHANNELS), 16'd100);
		queue_cmd(OP_SET_LEVEL, 3'(CODE_MAX), 16'd100);
		queue_cmd(OP_SET_TARGET, 3'd0, 16'd0);
		queue_cmd(OP_SET_TARGET, 3'd1, 16'(DUTY_MAX));
		queue_cmd(OP_SET_TARGET, 3'd2, 16'hFFFF);
		queue_cmd(OP_SET_TARGET, 3'd3, 16'd1000);
		queue_cmd(OP_SET_TARGET, 3'(CODE_MAX - 1), 16'd10);
		for (int op = int'(OP_FIRST_UNUSED); op <= CODE_MAX; op++)
			queue_cmd(3'(op), 3'd0, 16'h5A5A);
		queue_cmd(OP_TOGGLE_POWER, 3'd0, 16'd0);
		queue_cmd(OP_TOGGLE_POWER, 3'd0, 16'hFFFF);
		queue_cmd(OP_SET_BRIGHT, 3'd0, 16'd0);
		queue_cmd(OP_SET_BRIGHT, 3'd0, 16'd16384);
		queue_cmd(OP_SET_POWER, 3'd0, 16'hFFFF);
		wait_idle();

		run_phase(SQUARE_RESET, LINEAR_RESET, RANGE_RESET, IDLE_NONE, IDLE_NONE);
		run_phase(16'hFFFF, 20'hFFFFF, 16'hFFFF, IDLE_HALF, IDLE_NONE);
		run_phase(16'd0, 20'hFFFFF, 16'd1, IDLE_NONE, IDLE_HALF);
		// Largest curve and a zero divider: overflow and saturation.
		run_phase(16'hFFFF, 20'hFFFFF, 16'd0, IDLE_BOTH, IDLE_BOTH);
		run_phase(16'($urandom), 20'($urandom), 16'($urandom_range(1, 65535)),
			IDLE_NONE, IDLE_NONE);
		run_phase(16'd256, 20'd0, 16'd1, IDLE_HALF, IDLE_NONE);
		// A flat curve: every duty is zero and any nonzero target pushes the search towards full level.
		run_phase(16'd0, 20'd0, RANGE_RESET, IDLE_NONE, IDLE_HALF);
		run_phase(16'($urandom_range(20000)), 20'($urandom_range(16384)),
			16'($urandom_range(1, 8192)), IDLE_BOTH, IDLE_BOTH);

		if (duty_queue.size() != 0)
			report_mismatch($sformatf("%0d duty beats never arrived", duty_queue.size()));
		if (mismatch_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

FILE: led_color_pwm_dimmer_core.f
rtl/lcpd_pkg.sv
rtl/lcpd_in_if.sv
rtl/lcpd_out_if.sv
rtl/lcpd_div.sv
rtl/led_color_pwm_dimmer_core.sv
test/led_color_pwm_dimmer_core_test.sv
